// File: rtl/circle_centre_three_points_3d_assert.svh
// assertion macros shared by the circle centre rtl
// no dependencies; included by modules that carry concurrent checks
`ifndef CIRCLE_CENTRE_THREE_POINTS_3D_ASSERT_SVH
`define CIRCLE_CENTRE_THREE_POINTS_3D_ASSERT_SVH

// property must hold at every clock edge outside reset
`define CCP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true at a clock edge outside reset
`define CCP_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// File: rtl/ccp_pkg.sv
// shared constants and types for the circle centre pipeline
// no dependencies; imported by ccp_mul, ccp_div and the top level
package ccp_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int LIMB_W          = 32;

   typedef enum logic [1:0] {
      FIT_OK    = 2'd0,
      FIT_DEGEN = 2'd1,
      FIT_SAT   = 2'd2
   } fit_status_type;

   typedef struct packed {
      logic ovf;
      logic neg;
   } div_flags_type;

endpackage

// File: rtl/ccp_mul.sv
// signed multiplier cut into 32x32 limb products, four register stages
// depends on ccp_pkg
module ccp_mul import ccp_pkg::*; #(
   parameter int A_W = 33,
   parameter int B_W = 33
) (
   input  logic                     clock,
   input  logic signed [A_W-1:0]    op_a,
   input  logic signed [B_W-1:0]    op_b,
   output logic signed [A_W+B_W-1:0] prod
);

   localparam int NA    = (A_W + LIMB_W - 1) / LIMB_W;
   localparam int NB    = (B_W + LIMB_W - 1) / LIMB_W;
   localparam int PA_W  = NA * LIMB_W;
   localparam int PB_W  = NB * LIMB_W;
   localparam int ROW_W = PA_W + LIMB_W;
   localparam int SUM_W = PA_W + PB_W;
   localparam int P_W   = A_W + B_W;

   logic [A_W-1:0]        ua, mag_a_in, mag_a_ff;
   logic [B_W-1:0]        ub, mag_b_in, mag_b_ff;
   logic [2:0]            neg_ff;
   logic [PA_W-1:0]       la;
   logic [PB_W-1:0]       lb;
   logic [2*LIMB_W-1:0]   pp_ff [NA][NB];
   logic [ROW_W-1:0]      row_in [NB];
   logic [ROW_W-1:0]      row_ff [NB];
   logic [SUM_W-1:0]      tot;
   logic [P_W-1:0]        prod_in;
   logic [P_W-1:0]        prod_ff;

   always_comb begin
      ua       = $unsigned(op_a);
      ub       = $unsigned(op_b);
      mag_a_in = ua[A_W-1] ? (~ua + A_W'(1)) : ua;
      mag_b_in = ub[B_W-1] ? (~ub + B_W'(1)) : ub;
      la       = PA_W'(mag_a_ff);
      lb       = PB_W'(mag_b_ff);
   end

   // one row per limb of b
   always_comb begin
      for (int j = 0; j < NB; j++) begin
         row_in[j] = '0;
         for (int i = 0; i < NA; i++) begin
            row_in[j] = row_in[j] + (ROW_W'(pp_ff[i][j]) << (i * LIMB_W));
         end
      end
   end

   always_comb begin
      tot = '0;
      for (int j = 0; j < NB; j++) begin
         tot = tot + (SUM_W'(row_ff[j]) << (j * LIMB_W));
      end
      prod_in = neg_ff[2] ? P_W'(~tot + SUM_W'(1)) : P_W'(tot);
   end

   always_ff @(posedge clock) begin
      mag_a_ff  <= mag_a_in;
      mag_b_ff  <= mag_b_in;
      neg_ff[0] <= op_a[A_W-1] ^ op_b[B_W-1];
      neg_ff[1] <= neg_ff[0];
      neg_ff[2] <= neg_ff[1];
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            pp_ff[i][j] <= (2*LIMB_W)'(la[i*LIMB_W +: LIMB_W])
                         * (2*LIMB_W)'(lb[j*LIMB_W +: LIMB_W]);
         end
      end
      for (int j = 0; j < NB; j++) begin
         row_ff[j] <= row_in[j];
      end
      prod_ff <= prod_in;
   end

   assign prod = $signed(prod_ff);

endmodule

// File: rtl/ccp_div.sv
// pipelined restoring divider, one quotient bit per stage, rounds half away from zero
// depends on ccp_pkg
module ccp_div import ccp_pkg::*; #(
   parameter int COORD_W = COORD_WIDTH_DEF,
   localparam int NUM_W = 5 * COORD_W + 10,
   localparam int DEN_W = 4 * COORD_W + 9,
   localparam int QUO_W = COORD_W + 4
) (
   input  logic                    clock,
   input  logic signed [NUM_W-1:0] num,
   input  logic [DEN_W-1:0]        den,
   output logic signed [QUO_W-1:0] quo,
   output div_flags_type           flags
);

   localparam int QB    = COORD_W + 2;
   localparam int CMP_W = NUM_W + 1;

   logic [NUM_W-1:0]  unum;
   logic [NUM_W-1:0]  rem_ff [QB+1];
   logic [DEN_W-1:0]  den_ff [QB+1];
   logic [QB-1:0]     q_ff [QB+1];
   div_flags_type     fl_ff [QB+1];
   logic              rb;
   logic [QB:0]       rq_ff;
   div_flags_type     fl_r_ff;
   logic [QUO_W-1:0]  qext;
   logic [QUO_W-1:0]  quo_in, quo_ff;
   div_flags_type     flags_ff;

   assign unum = $unsigned(num);

   always_ff @(posedge clock) begin
      rem_ff[0] <= unum[NUM_W-1] ? (~unum + NUM_W'(1)) : unum;
      den_ff[0] <= den;
      q_ff[0]   <= '0;
      fl_ff[0]  <= '{ovf: 1'b0, neg: num[NUM_W-1]};
   end

   // the top step doubles as the range check: a set top bit means overflow
   for (genvar s = 0; s < QB; s++) begin : g_step
      localparam int J = QB - 1 - s;
      logic [CMP_W-1:0] dsh, rx;
      logic             ge;

      assign dsh = CMP_W'(den_ff[s]) << J;
      assign rx  = CMP_W'(rem_ff[s]);
      assign ge  = rx >= dsh;

      always_ff @(posedge clock) begin
         rem_ff[s+1] <= ge ? NUM_W'(rx - dsh) : rem_ff[s];
         den_ff[s+1] <= den_ff[s];
         q_ff[s+1]   <= q_ff[s] | (QB'(ge) << J);
         fl_ff[s+1]  <= '{ovf: (s == 0) ? ge : fl_ff[s].ovf, neg: fl_ff[s].neg};
      end
   end

   assign rb   = CMP_W'({rem_ff[QB], 1'b0}) >= CMP_W'(den_ff[QB]);
   assign qext = QUO_W'(rq_ff);
   assign quo_in = fl_r_ff.neg ? (~qext + QUO_W'(1)) : qext;

   always_ff @(posedge clock) begin
      rq_ff    <= (QB+1)'(q_ff[QB]) + (QB+1)'(rb);
      fl_r_ff  <= fl_ff[QB];
      quo_ff   <= quo_in;
      flags_ff <= fl_r_ff;
   end

   assign quo   = $signed(quo_ff);
   assign flags = flags_ff;

endmodule

// File: rtl/circle_centre_three_points_3d.sv
// top level: centre of the circle through three 3d points, fully pipelined
// depends on ccp_pkg, ccp_mul, ccp_div and circle_centre_three_points_3d_assert.svh
//
//   channel   direction  handshake             payload
//   request   in         start / busy          req_{first,second,third}_{x,y,z}
//   response  out        rsp_strobe (1 cycle)  rsp_centre_{x,y,z}, rsp_fit_status
//
// one transaction per cycle; between the accepting edge and the response lie
// an input register, three multiplier rounds of five stages each (four in the
// multiplier, one for the sum), a divider with one quotient bit per stage plus
// entry, rounding and sign stages, and the output register.
// busy is high only during reset; reset empties the pipeline.
// the receiver cannot stall, so the pipeline never holds.
`include "circle_centre_three_points_3d_assert.svh"

module circle_centre_three_points_3d import ccp_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_first_x,
   input  logic signed [COORD_WIDTH-1:0] req_first_y,
   input  logic signed [COORD_WIDTH-1:0] req_first_z,
   input  logic signed [COORD_WIDTH-1:0] req_second_x,
   input  logic signed [COORD_WIDTH-1:0] req_second_y,
   input  logic signed [COORD_WIDTH-1:0] req_second_z,
   input  logic signed [COORD_WIDTH-1:0] req_third_x,
   input  logic signed [COORD_WIDTH-1:0] req_third_y,
   input  logic signed [COORD_WIDTH-1:0] req_third_z,
   output logic                          rsp_strobe,
   output logic signed [COORD_WIDTH-1:0] rsp_centre_x,
   output logic signed [COORD_WIDTH-1:0] rsp_centre_y,
   output logic signed [COORD_WIDTH-1:0] rsp_centre_z,
   output logic [1:0]                    rsp_fit_status
);

   localparam int W      = COORD_WIDTH;
   localparam int AW     = W + 1;
   localparam int PW1    = 2 * W + 2;
   localparam int NVW    = 2 * W + 3;
   localparam int AAW    = 2 * W + 4;
   localparam int NSQW   = 4 * W + 6;
   localparam int NNW    = 4 * W + 8;
   localparam int PWV    = 3 * W + 5;
   localparam int WVW    = 3 * W + 6;
   localparam int PNUM   = 5 * W + 9;
   localparam int NUMW   = 5 * W + 10;
   localparam int DENW   = 4 * W + 9;
   localparam int QUOW   = W + 4;
   localparam int MUL_D  = 5;
   localparam int P1_DLY = W + 20;
   localparam int DG_DLY = W + 5;
   localparam int LAT    = W + 22;

   localparam logic signed [W-1:0] C_MAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] C_MIN = {1'b1, {(W-1){1'b0}}};

   logic                   accept;
   logic signed [W-1:0]    p1_in [3], p2_in [3], p3_in [3];

   // stage 0
   logic                   s0_vld_ff;
   logic signed [W-1:0]    p1_ff [3];
   logic signed [AW-1:0]   a_ff [3], b_ff [3];

   // first multiplier round
   logic signed [PW1-1:0]  cl [3], cr [3], sa [3], sb [3];
   logic signed [AW-1:0]   a_dl_ff [MUL_D][3];
   logic signed [AW-1:0]   b_dl_ff [MUL_D][3];
   logic signed [NVW-1:0]  n_ff [3];
   logic signed [AAW-1:0]  aa_ff, bb_ff;

   // second multiplier round
   logic signed [NSQW-1:0] nsq [3];
   logic signed [PWV-1:0]  wa [3], wb [3];
   logic signed [NVW-1:0]  n_dl_ff [MUL_D][3];
   logic signed [NNW-1:0]  nn_ff;
   logic signed [WVW-1:0]  wv_ff [3];

   // third multiplier round
   logic signed [PNUM-1:0] ml [3], mr [3];
   logic signed [NNW-1:0]  nn_dl_ff [MUL_D];
   logic signed [NUMW-1:0] num_ff [3];
   logic [DENW-1:0]        den;

   // divide and finish
   logic signed [QUOW-1:0] quo [3];
   div_flags_type          dfl [3];
   logic [DG_DLY-1:0]      deg_dl_ff;
   logic [P1_DLY-1:0]      vld_dl_ff;
   logic signed [W-1:0]    p1_dl_ff [P1_DLY][3];
   logic signed [QUOW-1:0] cc [3];
   logic signed [W-1:0]    cen_in [3];
   logic                   any_sat;
   logic                   deg;
   fit_status_type         status_in, status_ff;
   logic                   rsp_strobe_ff;
   logic signed [W-1:0]    cen_ff [3];

   assign busy   = reset;
   assign accept = start & ~busy;

   always_comb begin
      p1_in[0] = req_first_x;  p1_in[1] = req_first_y;  p1_in[2] = req_first_z;
      p2_in[0] = req_second_x; p2_in[1] = req_second_y; p2_in[2] = req_second_z;
      p3_in[0] = req_third_x;  p3_in[1] = req_third_y;  p3_in[2] = req_third_z;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         p1_ff[i] <= p1_in[i];
         a_ff[i]  <= AW'(p2_in[i]) - AW'(p1_in[i]);
         b_ff[i]  <= AW'(p3_in[i]) - AW'(p1_in[i]);
      end
   end

   // n = a x b, |a|^2, |b|^2
   for (genvar i = 0; i < 3; i++) begin : g_round1
      ccp_mul #(.A_W(AW), .B_W(AW)) u_cx_l (
         .clock(clock), .op_a(a_ff[(i+1)%3]), .op_b(b_ff[(i+2)%3]), .prod(cl[i]));
      ccp_mul #(.A_W(AW), .B_W(AW)) u_cx_r (
         .clock(clock), .op_a(a_ff[(i+2)%3]), .op_b(b_ff[(i+1)%3]), .prod(cr[i]));
      ccp_mul #(.A_W(AW), .B_W(AW)) u_sq_a (
         .clock(clock), .op_a(a_ff[i]), .op_b(a_ff[i]), .prod(sa[i]));
      ccp_mul #(.A_W(AW), .B_W(AW)) u_sq_b (
         .clock(clock), .op_a(b_ff[i]), .op_b(b_ff[i]), .prod(sb[i]));
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         a_dl_ff[0][i] <= a_ff[i];
         b_dl_ff[0][i] <= b_ff[i];
         for (int k = 1; k < MUL_D; k++) begin
            a_dl_ff[k][i] <= a_dl_ff[k-1][i];
            b_dl_ff[k][i] <= b_dl_ff[k-1][i];
         end
         n_ff[i] <= NVW'(cl[i]) - NVW'(cr[i]);
      end
      aa_ff <= AAW'(sa[0]) + AAW'(sa[1]) + AAW'(sa[2]);
      bb_ff <= AAW'(sb[0]) + AAW'(sb[1]) + AAW'(sb[2]);
   end

   // |n|^2 and w = |a|^2 b - |b|^2 a
   for (genvar i = 0; i < 3; i++) begin : g_round2
      ccp_mul #(.A_W(NVW), .B_W(NVW)) u_sq_n (
         .clock(clock), .op_a(n_ff[i]), .op_b(n_ff[i]), .prod(nsq[i]));
      ccp_mul #(.A_W(AAW), .B_W(AW)) u_w_a (
         .clock(clock), .op_a(aa_ff), .op_b(b_dl_ff[MUL_D-1][i]), .prod(wa[i]));
      ccp_mul #(.A_W(AAW), .B_W(AW)) u_w_b (
         .clock(clock), .op_a(bb_ff), .op_b(a_dl_ff[MUL_D-1][i]), .prod(wb[i]));
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         n_dl_ff[0][i] <= n_ff[i];
         for (int k = 1; k < MUL_D; k++) begin
            n_dl_ff[k][i] <= n_dl_ff[k-1][i];
         end
         wv_ff[i] <= WVW'(wa[i]) - WVW'(wb[i]);
      end
      nn_ff <= NNW'(nsq[0]) + NNW'(nsq[1]) + NNW'(nsq[2]);
   end

   // numerator = w x n
   for (genvar i = 0; i < 3; i++) begin : g_round3
      ccp_mul #(.A_W(WVW), .B_W(NVW)) u_num_l (
         .clock(clock), .op_a(wv_ff[(i+1)%3]), .op_b(n_dl_ff[MUL_D-1][(i+2)%3]),
         .prod(ml[i]));
      ccp_mul #(.A_W(WVW), .B_W(NVW)) u_num_r (
         .clock(clock), .op_a(wv_ff[(i+2)%3]), .op_b(n_dl_ff[MUL_D-1][(i+1)%3]),
         .prod(mr[i]));
   end

   always_ff @(posedge clock) begin
      nn_dl_ff[0] <= nn_ff;
      for (int k = 1; k < MUL_D; k++) begin
         nn_dl_ff[k] <= nn_dl_ff[k-1];
      end
      for (int i = 0; i < 3; i++) begin
         num_ff[i] <= NUMW'(ml[i]) - NUMW'(mr[i]);
      end
   end

   assign den = {$unsigned(nn_dl_ff[MUL_D-1]), 1'b0};

   for (genvar i = 0; i < 3; i++) begin : g_div
      ccp_div #(.COORD_W(W)) u_div (
         .clock(clock), .num(num_ff[i]), .den(den), .quo(quo[i]), .flags(dfl[i]));
   end

   // side band that rides alongside the datapath
   always_ff @(posedge clock) begin
      deg_dl_ff <= {deg_dl_ff[DG_DLY-2:0], (nn_dl_ff[MUL_D-1] == '0)};
      for (int i = 0; i < 3; i++) begin
         p1_dl_ff[0][i] <= p1_ff[i];
         for (int k = 1; k < P1_DLY; k++) begin
            p1_dl_ff[k][i] <= p1_dl_ff[k-1][i];
         end
      end
   end

   always_comb begin
      any_sat = 1'b0;
      deg     = deg_dl_ff[DG_DLY-1];
      for (int i = 0; i < 3; i++) begin
         cc[i] = QUOW'(p1_dl_ff[P1_DLY-1][i]) + quo[i];
         if (dfl[i].ovf) begin
            cen_in[i] = dfl[i].neg ? C_MIN : C_MAX;
            any_sat   = 1'b1;
         end else if (cc[i] > QUOW'(C_MAX)) begin
            cen_in[i] = C_MAX;
            any_sat   = 1'b1;
         end else if (cc[i] < QUOW'(C_MIN)) begin
            cen_in[i] = C_MIN;
            any_sat   = 1'b1;
         end else begin
            cen_in[i] = W'(cc[i]);
         end
         if (deg) begin
            cen_in[i] = '0;
         end
      end
      if (deg) begin
         status_in = FIT_DEGEN;
      end else if (any_sat) begin
         status_in = FIT_SAT;
      end else begin
         status_in = FIT_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff     <= 1'b0;
         vld_dl_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         s0_vld_ff     <= accept;
         vld_dl_ff     <= {vld_dl_ff[P1_DLY-2:0], s0_vld_ff};
         rsp_strobe_ff <= vld_dl_ff[P1_DLY-1];
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      for (int i = 0; i < 3; i++) begin
         cen_ff[i] <= cen_in[i];
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_centre_x   = cen_ff[0];
   assign rsp_centre_y   = cen_ff[1];
   assign rsp_centre_z   = cen_ff[2];
   assign rsp_fit_status = status_ff;

   `CCP_ASSERT(a_fixed_latency, clock, reset, accept |-> ##LAT rsp_strobe,
      "response missing after accept")
   `CCP_ASSERT(a_degen_zero, clock, reset,
      rsp_strobe && rsp_fit_status == FIT_DEGEN |->
         rsp_centre_x == '0 && rsp_centre_y == '0 && rsp_centre_z == '0,
      "degenerate response with nonzero centre")
   `CCP_ASSERT(a_sat_at_end, clock, reset,
      rsp_strobe && rsp_fit_status == FIT_SAT |->
         rsp_centre_x == C_MAX || rsp_centre_x == C_MIN ||
         rsp_centre_y == C_MAX || rsp_centre_y == C_MIN ||
         rsp_centre_z == C_MAX || rsp_centre_z == C_MIN,
      "saturated response with no clamped coordinate")
   `CCP_ASSERT_NEVER(a_quiet_after_reset, clock, reset, rsp_strobe && $past(reset),
      "response right after reset")

endmodule
